/* design/etx_lq_pkg.sv */
// ----------------------------------------------------------------------------
// etx_lq_pkg: shared types and constants of the link quality estimator
// Command codes, register indexes, step counts and the handshake structs
// between the top level and the serial ETX cost unit.
// ----------------------------------------------------------------------------
package etx_lq_pkg;

  localparam int unsigned QualityWidth = 16;
  localparam int unsigned CostWidth    = 24;
  localparam int unsigned MultWidth    = 17;
  localparam int unsigned WindowWidth  = 8;
  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 24;

  // A quality below 0.1 in Q0.16 marks the link as unusable
  localparam logic [QualityWidth-1:0] QualityFloor = 16'd6554;

  // Bit-serial step counts
  localparam int unsigned AvgSteps = 17;  // 17-bit dividend over the window
  localparam int unsigned MulSteps = 16;  // one neighbor quality bit per step
  localparam int unsigned DivSteps = 24;  // one cost bit per step
  localparam int unsigned CntWidth = 5;

  typedef enum logic [1:0] {
    CMD_RECEIVED = 2'd0,
    CMD_LOST     = 2'd1,
    CMD_SET_NBR  = 2'd2,
    CMD_CLEAR    = 2'd3
  } cmd_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_WINDOW_SIZE     = 2'd0,
    CFG_COST_MULTIPLIER = 2'd1,
    CFG_BROKEN_COST     = 2'd2,
    CFG_UNUSED          = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic                    start;
    logic [QualityWidth-1:0] lq;
    logic [QualityWidth-1:0] nlq;
    logic [MultWidth-1:0]    mult;
    logic [CostWidth-1:0]    broken;
  } cost_req_t;

  typedef struct packed {
    logic                 done;
    logic [CostWidth-1:0] cost;
  } cost_rsp_t;

endpackage

/* design/etx_link_quality_estimator.sv */
// ----------------------------------------------------------------------------
// etx_link_quality_estimator: link quality tracking with ETX cost
// Keeps local and neighbor link quality in Q0.16 and reports the ETX cost
// and both qualities as bytes after every event.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) transfers one event: command_i and
//   foreign_quality_i. Output channel (out_valid_o/out_ready_i) transfers one
//   result per event: link_cost_o, local_quality_byte_o, neighbor_quality_byte_o.
//   Events are handled one at a time. Packet received/lost events run a
//   bit-serial divider over the window, then the cost unit: a serial
//   multiply and a serial divide. Neighbor and clear events skip the
//   averaging. When either quality is below 0.1 the cost arithmetic is
//   skipped.
//   A new event is taken while a result still waits in the output register;
//   if the receiver stalls, the next result holds until the output register
//   frees up and no further event is taken.
//   Reset zeroes both qualities and loads window 12, multiplier 1024 and
//   broken cost 4194304. Write configuration only while no event is in flight.
// ----------------------------------------------------------------------------
module etx_link_quality_estimator
  import etx_lq_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              command_i,
  input  logic [QualityWidth-1:0] foreign_quality_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [CostWidth-1:0]    link_cost_o,
  output logic [7:0]              local_quality_byte_o,
  output logic [7:0]              neighbor_quality_byte_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_AVG  = 4'b0010,
    S_COST = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  state_e                  state_q, state_d;
  logic [WindowWidth-1:0]  window_q;
  logic [MultWidth-1:0]    mult_q;
  logic [CostWidth-1:0]    broken_q;
  logic [QualityWidth-1:0] lq_q, lq_d;
  logic [QualityWidth-1:0] nlq_q, nlq_d;
  logic                    recv_q, recv_d;
  logic                    start_q, start_d;
  logic [CntWidth-1:0]     cnt_q, cnt_d;
  logic [16:0]             dq_q, dq_d;   // q / w lane, quotient shifts in
  logic [16:0]             dk_q, dk_d;   // 65536 / w lane
  logic [8:0]              rq_q, rq_d;
  logic [8:0]              rk_q, rk_d;
  logic                    out_valid_q;
  logic [CostWidth-1:0]    cost_out_q;
  logic [7:0]              lq_byte_q, nlq_byte_q;

  logic [WindowWidth-1:0] w_eff;
  logic [8:0]             rq_sh, rk_sh;
  logic                   q_geq, k_geq;
  logic [16:0]            dq_step, dk_step;
  logic [17:0]            avg_sum;
  logic                   load_out;
  logic [23:0]            lq_scaled, nlq_scaled;
  cmd_e                   cmd;
  cost_req_t              req;
  cost_rsp_t              rsp;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WindowWidth'(12);
      mult_q   <= MultWidth'(1024);
      broken_q <= CostWidth'(4194304);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_WINDOW_SIZE:     window_q <= cfg_data_i[WindowWidth-1:0];
        CFG_COST_MULTIPLIER: mult_q   <= cfg_data_i[MultWidth-1:0];
        CFG_BROKEN_COST:     broken_q <= cfg_data_i[CostWidth-1:0];
        default: ;
      endcase
    end
  end

  assign w_eff = (window_q == '0) ? WindowWidth'(1) : window_q;
  assign cmd   = cmd_e'(command_i);

  // One restoring division step on each lane
  assign rq_sh   = {rq_q[7:0], dq_q[16]};
  assign rk_sh   = {rk_q[7:0], dk_q[16]};
  assign q_geq   = rq_sh >= {1'b0, w_eff};
  assign k_geq   = rk_sh >= {1'b0, w_eff};
  assign dq_step = {dq_q[15:0], q_geq};
  assign dk_step = {dk_q[15:0], k_geq};

  // q - q/w, plus 65536/w on a received packet, saturating
  assign avg_sum = 18'(lq_q - dq_step[15:0]) + (recv_q ? 18'(dk_step) : 18'd0);

  assign in_ready_o = (state_q == S_IDLE);
  assign load_out   = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    lq_d    = lq_q;
    nlq_d   = nlq_q;
    recv_d  = recv_q;
    start_d = 1'b0;
    cnt_d   = cnt_q;
    dq_d    = dq_q;
    dk_d    = dk_q;
    rq_d    = rq_q;
    rk_d    = rk_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (cmd)
            CMD_RECEIVED, CMD_LOST: begin
              recv_d  = (cmd == CMD_RECEIVED);
              dq_d    = {1'b0, lq_q};
              dk_d    = 17'h10000;
              rq_d    = '0;
              rk_d    = '0;
              cnt_d   = '0;
              state_d = S_AVG;
            end
            CMD_SET_NBR: begin
              nlq_d   = foreign_quality_i;
              start_d = 1'b1;
              state_d = S_COST;
            end
            default: begin
              lq_d    = '0;
              nlq_d   = '0;
              start_d = 1'b1;
              state_d = S_COST;
            end
          endcase
        end
      end
      S_AVG: begin
        rq_d  = q_geq ? 9'(rq_sh - {1'b0, w_eff}) : rq_sh;
        rk_d  = k_geq ? 9'(rk_sh - {1'b0, w_eff}) : rk_sh;
        dq_d  = dq_step;
        dk_d  = dk_step;
        cnt_d = cnt_q + CntWidth'(1);
        if (cnt_q == CntWidth'(AvgSteps - 1)) begin
          lq_d    = (avg_sum > 18'd65535) ? 16'hFFFF : avg_sum[15:0];
          start_d = 1'b1;
          state_d = S_COST;
        end
      end
      S_COST: begin
        if (rsp.done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      lq_q    <= '0;
      nlq_q   <= '0;
      start_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      lq_q    <= lq_d;
      nlq_q   <= nlq_d;
      start_q <= start_d;
      cnt_q   <= cnt_d;
    end
  end

  // Averaging datapath
  always_ff @(posedge clk_i) begin
    recv_q <= recv_d;
    dq_q   <= dq_d;
    dk_q   <= dk_d;
    rq_q   <= rq_d;
    rk_q   <= rk_d;
  end

  // Serial ETX cost
  assign req.start  = start_q;
  assign req.lq     = lq_q;
  assign req.nlq    = nlq_q;
  assign req.mult   = mult_q;
  assign req.broken = broken_q;

  etx_lq_cost u_cost (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // q * 255 as (q << 8) - q
  assign lq_scaled  = {lq_q, 8'd0} - 24'(lq_q);
  assign nlq_scaled = {nlq_q, 8'd0} - 24'(nlq_q);

  // Output register: load a finished result, drop it on transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      cost_out_q <= rsp.cost;
      lq_byte_q  <= lq_scaled[23:16];
      nlq_byte_q <= nlq_scaled[23:16];
    end
  end

  assign out_valid_o             = out_valid_q;
  assign link_cost_o             = cost_out_q;
  assign local_quality_byte_o    = lq_byte_q;
  assign neighbor_quality_byte_o = nlq_byte_q;

  // Checks
  a_cost_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> link_cost_o != '0)
    else $error("link cost reported as zero");

  a_cost_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && broken_q != '0) |-> link_cost_o <= broken_q)
    else $error("link cost above broken cost");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q != S_IDLE)
    else $error("event transfer did not start processing");

  a_done_in_cost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> state_q == S_COST)
    else $error("cost unit finished outside the cost phase");

endmodule

/* design/etx_lq_cost.sv */
// ----------------------------------------------------------------------------
// etx_lq_cost: serial ETX cost unit
// Forms lq*nlq by shift and add, one bit per cycle, then divides
// cost_multiplier*2^32 by it with a restoring divider, one quotient bit per
// cycle, and clamps the result into 1..broken_cost.
// ----------------------------------------------------------------------------
module etx_lq_cost
  import etx_lq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cost_req_t req_i,
  output cost_rsp_t rsp_o
);

  typedef enum logic [2:0] {
    C_IDLE = 3'b001,
    C_MUL  = 3'b010,
    C_DIV  = 3'b100
  } cstate_e;

  cstate_e                 state_q, state_d;
  logic [CntWidth-1:0]     cnt_q, cnt_d;
  logic [31:0]             acc_q, acc_d;
  logic [QualityWidth-1:0] mpl_q, mpl_d;
  logic [31:0]             rem_q, rem_d;
  logic [CostWidth-1:0]    quo_q, quo_d;
  logic [CostWidth-1:0]    cost_q, cost_d;
  logic                    done_q, done_d;

  logic [32:0]          rem_sh;
  logic                 rem_geq;
  logic [31:0]          acc_step;
  logic [CostWidth-1:0] quo_step;

  // Clamp into 1..broken, a zero result reports as one
  function automatic logic [CostWidth-1:0] clamp_cost(logic [CostWidth-1:0] c,
                                                      logic [CostWidth-1:0] b);
    logic [CostWidth-1:0] r;
    r = (c > b) ? b : c;
    if (r == '0) begin
      r = CostWidth'(1);
    end
    return r;
  endfunction

  // One multiply step and one divide step
  assign acc_step = {acc_q[30:0], 1'b0} + (mpl_q[QualityWidth-1] ? 32'(req_i.lq) : 32'd0);
  assign rem_sh   = {rem_q, 1'b0};
  assign rem_geq  = rem_sh >= {1'b0, acc_q};
  assign quo_step = {quo_q[CostWidth-2:0], rem_geq};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    mpl_d   = mpl_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    cost_d  = cost_q;
    done_d  = 1'b0;
    case (state_q)
      C_IDLE: begin
        if (req_i.start) begin
          if (req_i.lq < QualityFloor || req_i.nlq < QualityFloor) begin
            cost_d = clamp_cost(req_i.broken, req_i.broken);
            done_d = 1'b1;
          end else begin
            acc_d   = '0;
            mpl_d   = req_i.nlq;
            cnt_d   = '0;
            state_d = C_MUL;
          end
        end
      end
      C_MUL: begin
        acc_d = acc_step;
        mpl_d = {mpl_q[QualityWidth-2:0], 1'b0};
        cnt_d = cnt_q + CntWidth'(1);
        if (cnt_q == CntWidth'(MulSteps - 1)) begin
          // multiplier << 32 over the product: the top bits start the remainder
          rem_d   = {7'd0, req_i.mult, 8'd0};
          quo_d   = '0;
          cnt_d   = '0;
          state_d = C_DIV;
        end
      end
      C_DIV: begin
        rem_d = rem_geq ? 32'(rem_sh - {1'b0, acc_q}) : rem_sh[31:0];
        quo_d = quo_step;
        cnt_d = cnt_q + CntWidth'(1);
        if (cnt_q == CntWidth'(DivSteps - 1)) begin
          cost_d  = clamp_cost(quo_step, req_i.broken);
          done_d  = 1'b1;
          state_d = C_IDLE;
        end
      end
      default: begin
        state_d = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    mpl_q  <= mpl_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    cost_q <= cost_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.cost = cost_q;

endmodule

/* tb/etx_link_quality_estimator_test.sv */
// ----------------------------------------------------------------------------
// etx_link_quality_estimator_test: self-checking bench for the ETX estimator
// Drives packet, neighbor and clear events through the valid/ready input,
// predicts every cost and quality byte with its own model of the averaging
// and ETX arithmetic, and checks each result transfer in order. Runs through
// several register settings, extremes included, under changing idle patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import etx_lq_pkg::*;

typedef struct packed {
  logic [CostWidth-1:0] link_cost;
  logic [7:0]           local_byte;
  logic [7:0]           nbr_byte;
} link_result_t;

// Tracks both qualities and the registers, holds the results still owed
class link_cost_tracker;
  logic [WindowWidth-1:0]  window_size;
  logic [MultWidth-1:0]    cost_multiplier;
  logic [CostWidth-1:0]    broken_cost;
  logic [QualityWidth-1:0] local_q;
  logic [QualityWidth-1:0] nbr_q;
  link_result_t            owed_results[$];
  int unsigned             errors;

  function new();
    window_size     = 8'd12;
    cost_multiplier = 17'd1024;
    broken_cost     = 24'd4194304;
    local_q         = '0;
    nbr_q           = '0;
    errors          = 0;
  endfunction

  function void write_register(cfg_idx_e idx, logic [CfgDataWidth-1:0] data);
    case (idx)
      CFG_WINDOW_SIZE:     window_size     = data[WindowWidth-1:0];
      CFG_COST_MULTIPLIER: cost_multiplier = data[MultWidth-1:0];
      CFG_BROKEN_COST:     broken_cost     = data[CostWidth-1:0];
      default: ;
    endcase
  endfunction

  function int unsigned pending();
    return owed_results.size();
  endfunction

  // ETX cost: multiplier * 2^32 / (lq * nlq), clamped, never zero
  function logic [CostWidth-1:0] etx_cost();
    logic [63:0] den;
    logic [63:0] cost;
    if (local_q < QualityFloor || nbr_q < QualityFloor) begin
      cost = 64'(broken_cost);
    end else begin
      den  = 64'(local_q) * 64'(nbr_q);
      cost = (64'(cost_multiplier) << 32) / den;
      if (cost > 64'(broken_cost)) cost = 64'(broken_cost);
    end
    if (cost == 64'd0) cost = 64'd1;
    return cost[CostWidth-1:0];
  endfunction

  function logic [7:0] quality_byte(logic [QualityWidth-1:0] q);
    return 8'((32'(q) * 32'd255) >> 16);
  endfunction

  // Apply one event to the state and queue the result it owes
  function void note_event(cmd_e cmd, logic [QualityWidth-1:0] reported);
    int unsigned  w;
    int unsigned  q;
    link_result_t want;
    case (cmd)
      CMD_RECEIVED, CMD_LOST: begin
        w = (window_size == '0) ? 1 : int'(window_size);
        q = 32'(local_q) - 32'(local_q) / w;
        if (cmd == CMD_RECEIVED) begin
          q = q + 32'd65536 / w;
          if (q > 32'd65535) q = 32'd65535;
        end
        local_q = q[QualityWidth-1:0];
      end
      CMD_SET_NBR: nbr_q = reported;
      default: begin
        local_q = '0;
        nbr_q   = '0;
      end
    endcase
    want.link_cost  = etx_cost();
    want.local_byte = quality_byte(local_q);
    want.nbr_byte   = quality_byte(nbr_q);
    owed_results.push_back(want);
  endfunction

  function void compare_field(string label, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      errors++;
    end
  endfunction

  function void check_result(logic [CostWidth-1:0] cost, logic [7:0] lq_byte,
                             logic [7:0] nlq_byte);
    link_result_t want;
    if (owed_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual cost %0d lq %0d nlq %0d",
               $time, cost, lq_byte, nlq_byte);
      errors++;
      return;
    end
    want = owed_results.pop_front();
    compare_field("link_cost", want.link_cost, cost);
    compare_field("local_quality_byte", want.local_byte, lq_byte);
    compare_field("neighbor_quality_byte", want.nbr_byte, nlq_byte);
  endfunction
endclass

module etx_link_quality_estimator_test;

  localparam int unsigned QuietLimit   = 3000;
  localparam int unsigned PhaseItems   = 228;
  localparam int unsigned NumPhases    = 8;
  localparam int unsigned SettleCycles = 70;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [CfgIdxWidth-1:0]  cfg_index_i = '0;
  logic [CfgDataWidth-1:0] cfg_data_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [1:0]              command_i = '0;
  logic [QualityWidth-1:0] foreign_quality_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [CostWidth-1:0]    link_cost_o;
  logic [7:0]              local_quality_byte_o;
  logic [7:0]              neighbor_quality_byte_o;

  link_cost_tracker tracker = new();

  int unsigned sender_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;

  etx_link_quality_estimator u_top (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_we_i               (cfg_we_i),
    .cfg_index_i            (cfg_index_i),
    .cfg_data_i             (cfg_data_i),
    .in_valid_i             (in_valid_i),
    .in_ready_o             (in_ready_o),
    .command_i              (command_i),
    .foreign_quality_i      (foreign_quality_i),
    .out_valid_o            (out_valid_o),
    .out_ready_i            (out_ready_i),
    .link_cost_o            (link_cost_o),
    .local_quality_byte_o   (local_quality_byte_o),
    .neighbor_quality_byte_o(neighbor_quality_byte_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Check result transfers, then pick the next ready level
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        tracker.check_result(link_cost_o, local_quality_byte_o, neighbor_quality_byte_o);
      end
      if (stall_left != 0) begin
        stall_left  = stall_left - 1;
        out_ready_i <= 1'b0;
      end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
        // mostly single cycles, now and then a long hold
        stall_left  = ($urandom_range(9) == 0) ? $urandom_range(20, 100) : 0;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles == QuietLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic put_reg(input cfg_idx_e idx, input logic [CfgDataWidth-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    tracker.write_register(idx, data);
    @(posedge clk_i);
  endtask

  // Write all registers; upper data bits are random and must be dropped
  task automatic write_config(input logic [WindowWidth-1:0] window,
                              input logic [MultWidth-1:0] mult,
                              input logic [CostWidth-1:0] broken);
    put_reg(CFG_WINDOW_SIZE, {16'($urandom), window});
    put_reg(CFG_UNUSED, 24'($urandom));
    put_reg(CFG_COST_MULTIPLIER, {7'($urandom), mult});
    put_reg(CFG_BROKEN_COST, broken);
    cfg_we_i <= 1'b0;
  endtask

  // Present one event and hold it until the transfer
  task automatic send_event(input cmd_e cmd, input logic [QualityWidth-1:0] reported);
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 70)) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    command_i         <= cmd;
    foreign_quality_i <= reported;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_event(cmd, reported);
  endtask

  // Drop valid and wait for every owed result
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  // Mostly packet traffic, neighbor reports usable or not, some clears
  task automatic send_random_event();
    int unsigned             pick;
    logic [QualityWidth-1:0] reported;
    pick     = $urandom_range(99);
    reported = 16'($urandom);
    if (pick < 45) begin
      send_event(CMD_RECEIVED, reported);
    end else if (pick < 67) begin
      send_event(CMD_LOST, reported);
    end else if (pick < 93) begin
      case ($urandom_range(7))
        0: reported = 16'd0;
        1: reported = QualityFloor - 16'd1;
        2: reported = QualityFloor;
        3: reported = 16'hFFFF;
        4: ;
        default: reported = 16'($urandom_range(6554, 65535));
      endcase
      send_event(CMD_SET_NBR, reported);
    end else begin
      send_event(CMD_CLEAR, reported);
    end
  endtask

  initial begin
    logic [WindowWidth-1:0] window;
    logic [MultWidth-1:0]   mult;
    logic [CostWidth-1:0]   broken;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed events under the reset settings
    send_event(CMD_CLEAR, 16'hFFFF);
    send_event(CMD_SET_NBR, 16'd0);
    repeat (3) send_event(CMD_RECEIVED, 16'($urandom));
    send_event(CMD_SET_NBR, QualityFloor - 16'd1);
    send_event(CMD_SET_NBR, QualityFloor);
    send_event(CMD_SET_NBR, 16'hFFFF);
    repeat (2) send_event(CMD_LOST, 16'($urandom));
    repeat (6) send_event(CMD_RECEIVED, 16'($urandom));
    send_event(CMD_SET_NBR, 16'h8000);
    send_event(CMD_CLEAR, 16'h0000);
    send_event(CMD_RECEIVED, 16'hFFFF);
    send_event(CMD_LOST, 16'h0000);
    send_event(CMD_SET_NBR, 16'hFFFF);

    // Random phases, extremes first, then random settings
    for (int phase = 0; phase < NumPhases; phase++) begin
      wait_drained();
      case (phase)
        0: begin window = 8'd1;   mult = 17'd65536;  broken = 24'hFFFFFF;   end
        1: begin window = 8'd128; mult = 17'd1;      broken = 24'd1;        end
        2: begin window = 8'd0;   mult = 17'd0;      broken = 24'd4194304;  end
        3: begin window = 8'd255; mult = 17'h1FFFF;  broken = 24'd0;        end
        default: begin
          window = ($urandom_range(3) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(1, 32));
          mult   = 17'($urandom);
          broken = ($urandom_range(3) == 0) ? 24'($urandom_range(1, 200000))
                                            : 24'($urandom);
        end
      endcase
      write_config(window, mult, broken);
      case (phase % 4)
        0: begin sender_idle_pct = 0;  stall_pct = 0;  end
        1: begin sender_idle_pct = 46; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 46; end
        default: begin sender_idle_pct = 34; stall_pct = 34; end
      endcase
      repeat (PhaseItems) send_random_event();
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
design/etx_lq_pkg.sv
design/etx_lq_cost.sv
design/etx_link_quality_estimator.sv
tb/etx_link_quality_estimator_test.sv
